// ===== sv/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the HSV to RGB converter
// Sector codes, field widths and the fixed-point divide constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int HUE_W   = 9;
    localparam int CHAN_W  = 8;
    localparam int OFFS_W  = 6;   // sector offset, 0..60
    localparam int PROD_W  = 16;  // 8 x 8 products
    localparam int NUM_W   = 23;  // ramp numerator, up to 3,901,500
    localparam int QUO_W   = 9;   // estimated ramp quotient

    localparam logic [HUE_W-1:0] HUE_MAX   = 9'd359;
    localparam logic [HUE_W-1:0] HUE_60    = 9'd60;
    localparam logic [HUE_W-1:0] HUE_120   = 9'd120;
    localparam logic [HUE_W-1:0] HUE_180   = 9'd180;
    localparam logic [HUE_W-1:0] HUE_240   = 9'd240;
    localparam logic [HUE_W-1:0] HUE_300   = 9'd300;
    localparam logic [HUE_W-1:0] HUE_360   = 9'd360;

    localparam logic [PROD_W-1:0] CHAN_FULL = 16'd255;

    // Ramp divisor 60 * 255 and its reciprocal scaled by 2^32
    localparam int RAMP_DIV    = 15300;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_PROD_W = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RAMP_RECIP = 19'd280716;
    localparam logic [NUM_W-1:0]   RAMP_DIV_N = 23'd15300;

    typedef enum logic [2:0] {
        SEC_R_MAX_G_RISE = 3'd0,
        SEC_G_MAX_R_FALL = 3'd1,
        SEC_G_MAX_B_RISE = 3'd2,
        SEC_B_MAX_G_FALL = 3'd3,
        SEC_B_MAX_R_RISE = 3'd4,
        SEC_R_MAX_B_FALL = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [OFFS_W-1:0]   offset;
    } sector_info_t;

endpackage

// ===== sv/hsv_sector_decode.sv =====
// ----------------------------------------------------------------------------
// hsv_sector_decode: hue to sector and ramp offset
// Clamps the hue to 359, picks the 60-degree sector and the rising or
// falling offset of the ramp channel within it.
// ----------------------------------------------------------------------------
module hsv_sector_decode
    import hsv_pkg::*;
(
    input  logic [HUE_W-1:0] hue,
    output sector_info_t     info
);

    logic [HUE_W-1:0] hue_clamped;
    logic [HUE_W-1:0] diff;

    // Clamp out-of-range hue
    assign hue_clamped = (hue > HUE_MAX) ? HUE_MAX : hue;

    // Pick sector and offset
    always_comb
    begin
        if (hue_clamped < HUE_60)
        begin
            info.sector = SEC_R_MAX_G_RISE;
            diff        = hue_clamped;
        end
        else if (hue_clamped < HUE_120)
        begin
            info.sector = SEC_G_MAX_R_FALL;
            diff        = HUE_120 - hue_clamped;
        end
        else if (hue_clamped < HUE_180)
        begin
            info.sector = SEC_G_MAX_B_RISE;
            diff        = hue_clamped - HUE_120;
        end
        else if (hue_clamped < HUE_240)
        begin
            info.sector = SEC_B_MAX_G_FALL;
            diff        = HUE_240 - hue_clamped;
        end
        else if (hue_clamped < HUE_300)
        begin
            info.sector = SEC_B_MAX_R_RISE;
            diff        = hue_clamped - HUE_240;
        end
        else
        begin
            info.sector = SEC_R_MAX_B_FALL;
            diff        = HUE_360 - hue_clamped;
        end
        info.offset = diff[OFFS_W-1:0];
    end

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: pipelined HSV to RGB pixel converter
// done pulses after an accepted start has passed v1_reg, v2_reg, v3_reg, v4_reg and done_reg.
// Throughput: one transaction per clock; busy is held low.
// The ramp divide by 15300 is a reciprocal multiply with one correction
// step; these two multiplies set the stage count.
// Reset clears the valid pipeline only; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CHAN_W-1:0] saturation,
    input  logic [CHAN_W-1:0] brightness,
    output logic              done,
    output logic [CHAN_W-1:0] red_level,
    output logic [CHAN_W-1:0] green_level,
    output logic [CHAN_W-1:0] blue_level
);

    sector_info_t info_next;

    // Stage 1: decoded hue and captured channels
    logic              v1_reg;
    sector_info_t      info1_reg;
    logic [CHAN_W-1:0] s1_reg, b1_reg;

    // Stage 2: products
    logic              v2_reg;
    sector_info_t      info2_reg;
    logic [CHAN_W-1:0] b2_reg;
    logic [PROD_W-1:0] pmin2_reg, psv2_reg;

    // Stage 3: ramp numerator and min level
    logic              v3_reg;
    sector_info_t      info3_reg;
    logic [CHAN_W-1:0] b3_reg, lo3_reg;
    logic [NUM_W-1:0]  num3_reg;
    logic [PROD_W:0]   lo_sum;
    logic [NUM_W-1:0]  num_next;

    // Stage 4: quotient estimate
    logic              v4_reg;
    sector_info_t      info4_reg;
    logic [CHAN_W-1:0] b4_reg, lo4_reg;
    logic [NUM_W-1:0]  num4_reg;
    logic [QUO_W-1:0]  q4_reg;
    logic [RECIP_PROD_W-1:0] recip_prod;

    // Stage 5: corrected ramp and channel select
    logic              done_reg;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  ramp_q;
    logic [CHAN_W-1:0] ramp;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;

    assign busy = 1'b0;

    hsv_sector_decode u_decode
    (
        .hue  (hue),
        .info (info_next)
    );

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Stage 1: capture transaction
    always_ff @(posedge clk)
    begin
        info1_reg <= info_next;
        s1_reg    <= saturation;
        b1_reg    <= brightness;
    end

    // Stage 2: v*(255-s) and s*v
    always_ff @(posedge clk)
    begin
        info2_reg <= info1_reg;
        b2_reg    <= b1_reg;
        pmin2_reg <= PROD_W'(b1_reg) * (CHAN_FULL - PROD_W'(s1_reg));
        psv2_reg  <= PROD_W'(s1_reg) * PROD_W'(b1_reg);
    end

    // Stage 3: min = floor(p/255), numerator = 60*p + k*s*v
    assign lo_sum   = (PROD_W+1)'(pmin2_reg) + (PROD_W+1)'(1)
                    + (PROD_W+1)'(pmin2_reg >> CHAN_W);
    assign num_next = NUM_W'(pmin2_reg) * NUM_W'(60)
                    + NUM_W'(info2_reg.offset) * NUM_W'(psv2_reg);

    always_ff @(posedge clk)
    begin
        info3_reg <= info2_reg;
        b3_reg    <= b2_reg;
        lo3_reg   <= lo_sum[PROD_W-1:CHAN_W];
        num3_reg  <= num_next;
    end

    // Stage 4: reciprocal multiply, estimate low by at most one
    assign recip_prod = RECIP_PROD_W'(num3_reg) * RECIP_PROD_W'(RAMP_RECIP);

    always_ff @(posedge clk)
    begin
        info4_reg <= info3_reg;
        b4_reg    <= b3_reg;
        lo4_reg   <= lo3_reg;
        num4_reg  <= num3_reg;
        q4_reg    <= recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    end

    // Stage 5: correct quotient, route max/min/ramp to channels
    assign rem    = num4_reg - NUM_W'(q4_reg) * RAMP_DIV_N;
    assign ramp_q = (rem >= RAMP_DIV_N) ? (q4_reg + QUO_W'(1)) : q4_reg;
    assign ramp   = ramp_q[CHAN_W-1:0];

    always_comb
    begin
        case (info4_reg.sector)
            SEC_R_MAX_G_RISE:
            begin
                red_next = b4_reg;  green_next = ramp;    blue_next = lo4_reg;
            end
            SEC_G_MAX_R_FALL:
            begin
                red_next = ramp;    green_next = b4_reg;  blue_next = lo4_reg;
            end
            SEC_G_MAX_B_RISE:
            begin
                red_next = lo4_reg; green_next = b4_reg;  blue_next = ramp;
            end
            SEC_B_MAX_G_FALL:
            begin
                red_next = lo4_reg; green_next = ramp;    blue_next = b4_reg;
            end
            SEC_B_MAX_R_RISE:
            begin
                red_next = ramp;    green_next = lo4_reg; blue_next = b4_reg;
            end
            SEC_R_MAX_B_FALL:
            begin
                red_next = b4_reg;  green_next = lo4_reg; blue_next = ramp;
            end
            default:
            begin
                red_next = b4_reg;  green_next = b4_reg;  blue_next = b4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done        = done_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

`ifndef SYNTHESIS
    // Every accepted transaction produces exactly one strobe, after v1_reg to v4_reg and done_reg
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("missing done strobe");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v4_reg))
        else $error("done without a transaction in flight");

    // The reciprocal estimate is never more than one below the quotient
    a_single_correction: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (rem < (RAMP_DIV_N + RAMP_DIV_N)))
        else $error("ramp quotient needs more than one correction");
`endif

endmodule
